### hw/rtl/running_median_assert.svh
// Assertion macros shared by the running median RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef RUNNING_MEDIAN_ASSERT_SVH
`define RUNNING_MEDIAN_ASSERT_SVH

// Invariant checked on every clock edge outside reset.
`define RM_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Implication checked in the cycle after the trigger.
`define RM_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

### hw/rtl/rm_pkg.sv
// Package for the running median block: sizes, types and FSM states.
// No dependencies; imported by rm_cell, rm_chain and running_median.
`timescale 1ns / 1ps

package rm_pkg;

   localparam int CAPACITY    = 1024;
   localparam int SAMPLE_BITS = 32;
   localparam int MEDIAN_W    = 33;
   localparam int HELD_W      = 11;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int GROUP_SIZE  = 32;
   localparam int NGROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int SUM_W       = SAMPLE_BITS + 1;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = ((MEDIAN_W + HELD_W + 7) / 8) * 8;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [COUNT_W-1:0]            count_type;

   typedef struct packed {
      logic ins_en;
      logic occupied;
      logic sel_lo;
      logic sel_hi;
   } rm_cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEL,
      ST_RED
   } rm_state_type;

endpackage

### hw/rtl/rm_cell.sv
// One compare-and-shift cell of the sorted chain.
// Depends on rm_pkg.
`timescale 1ns / 1ps

module rm_cell
   import rm_pkg::*;
(
   input  logic            clock,
   input  rm_cell_ctl_type ctl,
   input  sample_type      sample,
   input  logic            prev_keep,
   input  sample_type      prev_value,
   output logic            keep,
   output sample_type      value,
   output sample_type      lo_tap,
   output sample_type      hi_tap
);

   sample_type value_ff;
   sample_type value_in;

   // keep: this entry stays put; otherwise take the sample or shift up
   assign keep     = ctl.occupied && (value_ff <= sample);
   assign value_in = keep ? value_ff : (prev_keep ? sample : prev_value);

   always_ff @(posedge clock) begin
      if (ctl.ins_en) begin
         value_ff <= value_in;
      end
   end

   assign value  = value_ff;
   assign lo_tap = ctl.sel_lo ? value_ff : '0;
   assign hi_tap = ctl.sel_hi ? value_ff : '0;

endmodule

### hw/rtl/rm_chain.sv
// Row of rm_cell instances holding the sorted samples, plus the first
// registered stage of the median tap selection. Depends on rm_pkg, rm_cell.
`timescale 1ns / 1ps

module rm_chain
   import rm_pkg::*;
(
   input  logic                             clock,
   input  logic                             ins_en,
   input  sample_type                       sample,
   input  count_type                        count,
   output logic [NGROUPS-1:0][SAMPLE_BITS-1:0] grp_lo,
   output logic [NGROUPS-1:0][SAMPLE_BITS-1:0] grp_hi
);

   logic                                 keep    [CAPACITY];
   sample_type                           value   [CAPACITY];
   sample_type                           lo_taps [NGROUPS*GROUP_SIZE];
   sample_type                           hi_taps [NGROUPS*GROUP_SIZE];
   count_type                            lo_idx;
   count_type                            hi_idx;
   logic [NGROUPS-1:0][SAMPLE_BITS-1:0]  grp_lo_in;
   logic [NGROUPS-1:0][SAMPLE_BITS-1:0]  grp_hi_in;
   logic [NGROUPS-1:0][SAMPLE_BITS-1:0]  grp_lo_ff;
   logic [NGROUPS-1:0][SAMPLE_BITS-1:0]  grp_hi_ff;

   assign lo_idx = (count - count_type'(1)) >> 1;
   assign hi_idx = count >> 1;

   for (genvar i = 0; i < NGROUPS * GROUP_SIZE; i++) begin : g_cell
      if (i < CAPACITY) begin : g_used
         rm_cell_ctl_type ctl;
         assign ctl.ins_en   = ins_en;
         assign ctl.occupied = count_type'(i) < count;
         assign ctl.sel_lo   = count_type'(i) == lo_idx;
         assign ctl.sel_hi   = count_type'(i) == hi_idx;

         if (i == 0) begin : g_head
            rm_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .sample     (sample),
               .prev_keep  (1'b1),
               .prev_value (sample),
               .keep       (keep[i]),
               .value      (value[i]),
               .lo_tap     (lo_taps[i]),
               .hi_tap     (hi_taps[i])
            );
         end else begin : g_body
            rm_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .sample     (sample),
               .prev_keep  (keep[i-1]),
               .prev_value (value[i-1]),
               .keep       (keep[i]),
               .value      (value[i]),
               .lo_tap     (lo_taps[i]),
               .hi_tap     (hi_taps[i])
            );
         end
      end else begin : g_pad
         assign lo_taps[i] = '0;
         assign hi_taps[i] = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         grp_lo_in[g] = '0;
         grp_hi_in[g] = '0;
         for (int m = 0; m < GROUP_SIZE; m++) begin
            grp_lo_in[g] = grp_lo_in[g] | lo_taps[g*GROUP_SIZE+m];
            grp_hi_in[g] = grp_hi_in[g] | hi_taps[g*GROUP_SIZE+m];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_lo_ff <= grp_lo_in;
      grp_hi_ff <= grp_hi_in;
   end

   assign grp_lo = grp_lo_ff;
   assign grp_hi = grp_hi_ff;

endmodule

### hw/rtl/running_median.sv
// Top level of the running median block: stream ports, control FSM,
// final tap reduction and output register. Depends on rm_pkg, rm_chain.
`timescale 1ns / 1ps
`include "running_median_assert.svh"

// Exact running median over up to CAPACITY (1024) signed samples. Each
// accepted sample is inserted into a chain of compare-and-shift cells kept
// in ascending order; the middle entries are then picked out through a
// two-level OR tree of one-hot taps (32 cells per group, then 32 groups).
// After a sample is accepted the FSM passes through ST_SEL, where the group
// taps are registered, and ST_RED, where the result is loaded once the output
// register is free, before returning to ST_IDLE for the next sample; the block
// works on one sample at a time. The result is twice the median (the middle
// sample doubled for an odd count, the two middle samples summed for an even
// count), with the count now held; when the store is full the sample is
// discarded, tuser is set and the previous median is repeated. A result
// waiting in the output register does not block the next sample; that
// sample's result then waits inside the block and holds off further input
// until the output is taken. Reset needs no clearing pass.
module running_median
   import rm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [32:0] median_twice, [43:33] samples_held
   output logic                   rsp_tuser    // [0] dropped
);

   rm_state_type                        state_ff, state_in;
   count_type                           count_ff, count_in;
   logic                                drop_ff, drop_in;
   logic [MEDIAN_W-1:0]                 last_median_ff, last_median_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [MEDIAN_W-1:0]                 rsp_median_ff, rsp_median_in;
   logic [HELD_W-1:0]                   rsp_held_ff, rsp_held_in;
   logic                                rsp_drop_ff, rsp_drop_in;
   logic                                accept;
   logic                                full;
   logic                                ins_en;
   logic                                load;
   sample_type                          sample;
   logic [NGROUPS-1:0][SAMPLE_BITS-1:0] grp_lo;
   logic [NGROUPS-1:0][SAMPLE_BITS-1:0] grp_hi;
   sample_type                          lo_val;
   sample_type                          hi_val;
   logic signed [SUM_W-1:0]             sum;
   logic [MEDIAN_W-1:0]                 median;

   assign sample = sample_type'(req_tdata[SAMPLE_BITS-1:0]);
   assign full   = count_ff == count_type'(CAPACITY);
   assign accept = req_tvalid && req_tready;
   assign ins_en = accept && !full;

   rm_chain u_chain (
      .clock  (clock),
      .ins_en (ins_en),
      .sample (sample),
      .count  (count_ff),
      .grp_lo (grp_lo),
      .grp_hi (grp_hi)
   );

   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         lo_val = lo_val | grp_lo[g];
         hi_val = hi_val | grp_hi[g];
      end
   end

   assign sum    = SUM_W'(lo_val) + SUM_W'(hi_val);
   assign median = drop_ff ? last_median_ff : MEDIAN_W'(sum);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      drop_in        = drop_ff;
      last_median_in = last_median_ff;
      rsp_median_in  = rsp_median_ff;
      rsp_held_in    = rsp_held_ff;
      rsp_drop_in    = rsp_drop_ff;
      req_tready     = 1'b0;
      load           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               drop_in  = full;
               state_in = ST_SEL;
               if (!full) begin
                  count_in = count_ff + count_type'(1);
               end
            end
         end
         ST_SEL: begin
            state_in = ST_RED;
         end
         ST_RED: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load           = 1'b1;
               rsp_median_in  = median;
               rsp_held_in    = HELD_W'(count_ff);
               rsp_drop_in    = drop_ff;
               last_median_in = median;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         last_median_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         last_median_ff <= last_median_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_ff       <= drop_in;
      rsp_median_ff <= rsp_median_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-MEDIAN_W-HELD_W){1'b0}}, rsp_held_ff, rsp_median_ff};
   assign rsp_tuser  = rsp_drop_ff;

   `RM_ASSERT_ALWAYS(a_count_bound, count_ff <= count_type'(CAPACITY), "held count above capacity")
   `RM_ASSERT_NEXT(a_full_hold, accept && full, count_ff == $past(count_ff), "count moved on drop")
   `RM_ASSERT_NEXT(a_insert_count, ins_en, count_ff == $past(count_ff) + count_type'(1), "count not bumped on insert")
   `RM_ASSERT_NEXT(a_last_median, load, last_median_ff == rsp_median_ff, "last median not tracking result")

endmodule
